[sv/dirty_region_accumulator_assert.svh]
// Assertion macros for the dirty region accumulator checker.
// No dependencies; included by the checker file.
`ifndef DIRTY_REGION_ACCUMULATOR_ASSERT_SVH
`define DIRTY_REGION_ACCUMULATOR_ASSERT_SVH

// Same-cycle implication, disabled in reset
`define DRA_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("dirty_region_accumulator check failed");

// Next-cycle implication, disabled in reset
`define DRA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("dirty_region_accumulator check failed");

`endif

[sv/dra_pkg.sv]
// Shared types and constants for the dirty region accumulator.
// No dependencies.
`default_nettype none
package dra_pkg;

    // Command codes
    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam int CW_COORD = 16;
    localparam int AREA_W   = 36;   // 18 x 18 signed product
    localparam int NW       = 5;    // n and n+1, at most 16
    localparam int LIM_W    = 4;
    localparam logic [LIM_W-1:0] LIMIT_RESET = 4'd8;

    typedef struct packed {
        logic        [1:0]  cmd;
        logic signed [15:0] left;
        logic signed [15:0] top;
        logic signed [15:0] right;
        logic signed [15:0] bottom;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] rect_x;
        logic signed [15:0] rect_y;
        logic        [16:0] rect_w;
        logic        [16:0] rect_h;
        logic               empty_res;
        logic               last;
    } out_item_t;

    typedef struct packed {
        logic signed [15:0] x1;
        logic signed [15:0] y1;
        logic signed [15:0] x2;
        logic signed [15:0] y2;
    } box_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic clr_idx;
        logic inc_idx;
        logic first_add;
        logic merge_hit;
        logic append;
        logic clear;
        logic calc_area;
        logic acc;
        logic calc_barea;
        logic calc_prod;
        logic out_entry;
        logic out_bbox;
        logic out_empty;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [1:0] cmd;
        logic       cnt_zero;
        logic       cnt_one;
        logic       idx_last;
        logic       hit;
        logic       all_ok;
        logic       out_busy;
    } dp_stat_t;

endpackage
`default_nettype wire

[sv/dra_datapath.sv]
// Datapath: region memory, bounding box, area accumulation, overhead test, output register.
// Depends on dra_pkg.
`default_nettype none
module dra_datapath import dra_pkg::*; #(
    parameter int TABLE_DEPTH = 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_wr_en,
    input  wire logic [LIM_W-1:0] cfg_wr_data,
    input  wire in_item_t         s_data,
    input  wire logic             m_ready,
    output logic                  m_valid,
    output out_item_t             m_data,
    input  wire dp_cmd_t          cmd,
    output dp_stat_t              stat
);
    localparam int IW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNTW = $clog2(TABLE_DEPTH + 1);
    localparam int TW   = AREA_W + 1 + $clog2(TABLE_DEPTH);
    localparam int CMW  = TW + NW + 1;
    localparam logic [7:0] MAX8 = 8'(TABLE_DEPTH);

    box_t                   mem [TABLE_DEPTH];
    in_item_t               in_reg;
    box_t                   bbox_reg, bbox_next;
    box_t                   rd_reg;
    logic [CNTW-1:0]        count_reg, count_next;
    logic [CNTW-1:0]        idx_reg, idx_next;
    logic [LIM_W-1:0]       limit_reg;
    logic signed [AREA_W-1:0] area_reg;
    logic signed [TW-1:0]   total_reg;
    logic signed [CMW-1:0]  p_reg, t_reg;
    logic                   out_valid_reg;
    out_item_t              out_reg, out_next;
    logic                   out_load;
    box_t                   new_box, hit_merged;
    logic                   we;
    logic [IW-1:0]          waddr;
    box_t                   wdata;
    logic [7:0]             lim8, cnt8;
    logic [NW-1:0]          n_val, d_val;
    box_t                   area_src;
    logic signed [17:0]     dx, dy;

    assign new_box = '{x1: in_reg.left, y1: in_reg.top, x2: in_reg.right, y2: in_reg.bottom};

    function automatic box_t merge_box(box_t a, box_t b);
        box_t r;
        r    = a;
        if (b.x1 < a.x1) r.x1 = b.x1;
        if (b.y1 < a.y1) r.y1 = b.y1;
        if (b.x2 > a.x2) r.x2 = b.x2;
        if (b.y2 > a.y2) r.y2 = b.y2;
        return r;
    endfunction

    // Intersect, or share one axis span with a ending just before b starts on the other
    function automatic logic touch(box_t a, box_t b);
        logic signed [16:0] bx2m, by2m, bx1m, by1m;
        bx2m = 17'(b.x2) - 17'sd1;
        by2m = 17'(b.y2) - 17'sd1;
        bx1m = 17'(b.x1) - 17'sd1;
        by1m = 17'(b.y1) - 17'sd1;
        if (a.x1 <= b.x2 && a.x2 >= b.x1 && a.y1 <= b.y2 && a.y2 >= b.y1)
            return 1'b1;
        if (a.x1 == b.x1 && a.x2 == b.x2)
            return (17'(a.y1) == by2m) || (17'(a.y2) == by1m);
        if (a.y1 == b.y1 && a.y2 == b.y2)
            return (17'(a.x1) == bx2m) || (17'(a.x2) == bx1m);
        return 1'b0;
    endfunction

    function automatic out_item_t emit(box_t r, logic is_last);
        out_item_t o;
        o.rect_x    = r.x1;
        o.rect_y    = r.y1;
        o.rect_w    = 17'(17'(r.x2) - 17'(r.x1) + 17'sd1);
        o.rect_h    = 17'(17'(r.y2) - 17'(r.y1) + 17'sd1);
        o.empty_res = 1'b0;
        o.last      = is_last;
        return o;
    endfunction

    // Effective limit and overhead factor n = lim - count + 1, or 1 when count exceeds lim
    always_comb begin
        lim8 = 8'(limit_reg);
        if (lim8 == 8'd0) lim8 = 8'd1;
        if (lim8 > MAX8) lim8 = MAX8;
        cnt8 = 8'(count_reg);
        if (cnt8 > lim8) n_val = NW'(1);
        else n_val = NW'(lim8 - cnt8 + 8'd1);
        d_val = n_val + NW'(1);
    end

    assign hit_merged = merge_box(rd_reg, new_box);
    assign bbox_next  = merge_box(bbox_reg, new_box);

    // Memory write port selection
    always_comb begin
        we         = 1'b0;
        waddr      = '0;
        wdata      = new_box;
        count_next = count_reg;
        if (cmd.first_add) begin
            we         = 1'b1;
            count_next = CNTW'(1);
        end else if (cmd.merge_hit) begin
            we    = 1'b1;
            waddr = idx_reg[IW-1:0];
            wdata = hit_merged;
        end else if (cmd.append) begin
            we = 1'b1;
            if (cnt8 >= lim8) begin
                wdata      = bbox_next;
                count_next = CNTW'(1);
            end else begin
                waddr      = count_reg[IW-1:0];
                count_next = count_reg + CNTW'(1);
            end
        end else if (cmd.clear) begin
            count_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rd_reg <= mem[idx_reg[IW-1:0]];
    end

    // Index counter
    always_comb begin
        idx_next = idx_reg;
        if (cmd.clr_idx) idx_next = '0;
        else if (cmd.inc_idx) idx_next = idx_reg + CNTW'(1);
    end

    // Area operand: stored entry or bounding box
    assign area_src = cmd.calc_barea ? bbox_reg : rd_reg;
    assign dx = 18'(area_src.x2) - 18'(area_src.x1) + 18'sd1;
    assign dy = 18'(area_src.y2) - 18'(area_src.y1) + 18'sd1;

    // Output register load
    always_comb begin
        out_load = cmd.out_entry | cmd.out_bbox | cmd.out_empty;
        out_next = out_reg;
        if (cmd.out_empty) begin
            out_next           = '0;
            out_next.empty_res = 1'b1;
            out_next.last      = 1'b1;
        end else if (cmd.out_bbox) begin
            out_next = emit(bbox_reg, 1'b1);
        end else if (cmd.out_entry) begin
            out_next = emit(rd_reg, stat.idx_last);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            limit_reg     <= LIMIT_RESET;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end else begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
            if (cfg_wr_en) limit_reg <= cfg_wr_data;
            if (out_load) out_valid_reg <= 1'b1;
            else if (m_ready) out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load_in) in_reg <= s_data;
        if (cmd.first_add) bbox_reg <= new_box;
        else if (cmd.merge_hit || cmd.append) bbox_reg <= bbox_next;
        if (cmd.calc_area || cmd.calc_barea) area_reg <= dx * dy;
        if (cmd.clr_idx) total_reg <= '0;
        else if (cmd.acc) total_reg <= total_reg + TW'(area_reg);
        if (cmd.calc_prod) begin
            p_reg <= CMW'(area_reg) * CMW'($signed({1'b0, n_val}));
            t_reg <= CMW'(total_reg) * CMW'($signed({1'b0, d_val}));
        end
        if (out_load) out_reg <= out_next;
    end

    // total < bound*n/(n+1), truncating toward zero, without a divider
    always_comb begin
        stat.cmd      = in_reg.cmd;
        stat.cnt_zero = (count_reg == '0);
        stat.cnt_one  = (count_reg == CNTW'(1));
        stat.idx_last = (idx_reg == count_reg - CNTW'(1));
        stat.hit      = touch(rd_reg, new_box);
        stat.out_busy = out_valid_reg;
        if (!p_reg[CMW-1]) stat.all_ok = (t_reg + CMW'($signed({1'b0, d_val}))) <= p_reg;
        else stat.all_ok = t_reg < p_reg;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;
endmodule
`default_nettype wire

[sv/dra_ctrl.sv]
// Controller state machine sequencing add, read-out and clear transactions.
// Depends on dra_pkg.
`default_nettype none
module dra_ctrl import dra_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);
    typedef enum logic [13:0] {
        ST_IDLE    = 14'b00000000000001,
        ST_DECODE  = 14'b00000000000010,
        ST_ADD_RD  = 14'b00000000000100,
        ST_ADD_CHK = 14'b00000000001000,
        ST_SUM_RD  = 14'b00000000010000,
        ST_SUM_MUL = 14'b00000000100000,
        ST_SUM_ACC = 14'b00000001000000,
        ST_BND     = 14'b00000010000000,
        ST_PROD    = 14'b00000100000000,
        ST_CMP     = 14'b00001000000000,
        ST_EM_RD   = 14'b00010000000000,
        ST_EM_WAIT = 14'b00100000000000,
        ST_FIN     = 14'b01000000000000,
        ST_EM_LD   = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                state_next = ST_IDLE;
                case (stat.cmd)
                    CMD_ADD: begin
                        if (stat.cnt_zero) cmd.first_add = 1'b1;
                        else begin
                            cmd.clr_idx = 1'b1;
                            state_next  = ST_ADD_RD;
                        end
                    end
                    CMD_READ: begin
                        if (stat.cnt_zero) begin
                            cmd.out_empty = 1'b1;
                            state_next    = ST_FIN;
                        end else if (stat.cnt_one) begin
                            cmd.out_bbox = 1'b1;
                            state_next   = ST_FIN;
                        end else begin
                            cmd.clr_idx = 1'b1;
                            state_next  = ST_SUM_RD;
                        end
                    end
                    CMD_CLEAR: cmd.clear = 1'b1;
                    default: state_next = ST_IDLE;
                endcase
            end
            // Scan for the first matching entry
            ST_ADD_RD: state_next = ST_ADD_CHK;
            ST_ADD_CHK: begin
                if (stat.hit) begin
                    cmd.merge_hit = 1'b1;
                    state_next    = ST_IDLE;
                end else if (stat.idx_last) begin
                    cmd.append = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    cmd.inc_idx = 1'b1;
                    state_next  = ST_ADD_RD;
                end
            end
            // Sum the stored areas
            ST_SUM_RD: state_next = ST_SUM_MUL;
            ST_SUM_MUL: begin
                cmd.calc_area = 1'b1;
                state_next    = ST_SUM_ACC;
            end
            ST_SUM_ACC: begin
                cmd.acc = 1'b1;
                if (stat.idx_last) state_next = ST_BND;
                else begin
                    cmd.inc_idx = 1'b1;
                    state_next  = ST_SUM_RD;
                end
            end
            ST_BND: begin
                cmd.calc_barea = 1'b1;
                state_next     = ST_PROD;
            end
            ST_PROD: begin
                cmd.calc_prod = 1'b1;
                state_next    = ST_CMP;
            end
            ST_CMP: begin
                if (stat.all_ok) begin
                    cmd.clr_idx = 1'b1;
                    state_next  = ST_EM_LD;
                end else begin
                    cmd.out_bbox = 1'b1;
                    state_next   = ST_FIN;
                end
            end
            // Emit every entry, one transaction each; ST_EM_LD waits for the table read
            ST_EM_LD: state_next = ST_EM_RD;
            ST_EM_RD: begin
                if (!stat.out_busy) begin
                    cmd.out_entry = 1'b1;
                    state_next    = ST_EM_WAIT;
                end
            end
            ST_EM_WAIT: begin
                if (!stat.out_busy) begin
                    if (stat.idx_last) state_next = ST_IDLE;
                    else begin
                        cmd.inc_idx = 1'b1;
                        state_next  = ST_EM_LD;
                    end
                end
            end
            ST_FIN: begin
                if (!stat.out_busy) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else state_reg <= state_next;
    end
endmodule
`default_nettype wire

[sv/dirty_region_accumulator.sv]
// Dirty region accumulator: top level joining controller and datapath.
// Depends on dra_pkg, dra_ctrl, dra_datapath.
//
// One transaction at a time. A clear, or an add on an empty table, ends
// in the decode state; other adds scan the stored entries until the first
// match (one memory read per entry). A read-out with at most one entry
// loads its result into the output register in the decode state; otherwise
// it sums the stored areas (read, multiply, accumulate per entry), then
// computes the bounding area and the overhead compare. If that fails it
// emits the bounding box alone, else each stored rectangle in turn (table
// read, output load, handshake, advance), waiting while the output stalls.
// The region table has a single read port, read once per cycle.
`default_nettype none
module dirty_region_accumulator import dra_pkg::*; #(
    parameter int TABLE_DEPTH = 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_wr_en,
    input  wire logic [LIM_W-1:0] cfg_wr_data,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire in_item_t         s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output out_item_t             m_data
);
    dp_cmd_t  cmd;
    dp_stat_t stat;

    dra_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    dra_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_data      (s_data),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_data      (m_data),
        .cmd         (cmd),
        .stat        (stat)
    );
endmodule
`default_nettype wire

[sv/dra_checker.sv]
// Port-level checker for the dirty region accumulator, bound to the top level.
// Depends on dra_pkg and dirty_region_accumulator_assert.svh.
`default_nettype none
`include "dirty_region_accumulator_assert.svh"
module dra_checker import dra_pkg::*; (
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_valid,
    input wire logic      s_ready,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_item_t m_data
);
    // Stalled result holds
    `DRA_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
    // One transaction at a time: busy right after accepting
    `DRA_ASSERT_NEXT(a_busy, aclk, aresetn, s_valid && s_ready, !s_ready)
    // No new transaction while a result is pending
    `DRA_ASSERT_NOW(a_excl, aclk, aresetn, m_valid, !s_ready)
    // Empty result is a single-transaction run
    `DRA_ASSERT_NOW(a_empty, aclk, aresetn, m_valid && m_data.empty_res,
        m_data.last && m_data.rect_w == 17'd0)
endmodule

bind dirty_region_accumulator dra_checker u_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
`default_nettype wire
